@@ sv/tmc_pkg.sv @@
// Package for the text-mode console engine: screen geometry, operation codes
// and the request and response beat payload types. No dependencies.
`timescale 1ns / 1ps
package tmc_pkg;
   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int PAGE_COUNT  = 8;
   localparam int PLANE_CELLS = ROWS * COLUMNS;
   localparam int ALL_CELLS   = PAGE_COUNT * PLANE_CELLS;

   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int PAGE_W = 3;
   localparam int IDX_W  = $clog2(PLANE_CELLS);
   localparam int MEM_W  = $clog2(ALL_CELLS);
   localparam int CNT_W  = $clog2(PLANE_CELLS + 1);

   localparam logic [15:0] BLANK_CELL = 16'h0720;

   localparam logic [3:0] OP_SETMODE    = 4'd0;
   localparam logic [3:0] OP_SETCURSOR  = 4'd1;
   localparam logic [3:0] OP_READCURSOR = 4'd2;
   localparam logic [3:0] OP_SELECTPAGE = 4'd3;
   localparam logic [3:0] OP_SCROLLUP   = 4'd4;
   localparam logic [3:0] OP_SCROLLDOWN = 4'd5;
   localparam logic [3:0] OP_READCELL   = 4'd6;
   localparam logic [3:0] OP_WRITEREP   = 4'd7;
   localparam logic [3:0] OP_TELETYPE   = 4'd8;
   localparam logic [3:0] OP_GETSTATE   = 4'd9;

   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_BEL = 8'h07;
   localparam logic [7:0] CH_SPC = 8'h20;

   typedef struct packed {
      logic [3:0]  op;
      logic [7:0]  arg_byte;
      logic [7:0]  page_arg;
      logic [7:0]  attribute;
      logic [15:0] start_or_count;
      logic [15:0] end_or_position;
   } req_type;

   typedef struct packed {
      logic [7:0]        read_char;
      logic [7:0]        read_attr;
      logic [ROW_W-1:0]  cursor_row;
      logic [COL_W-1:0]  cursor_col;
      logic [PAGE_W-1:0] active_page;
      logic              status;
   } rsp_type;
endpackage

@@ sv/tmc_if.sv @@
// Valid/ready channel interfaces for request and response beats.
// Depends on tmc_pkg.
`timescale 1ns / 1ps
interface tmc_req_if import tmc_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface tmc_rsp_if import tmc_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ sv/tmc_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module tmc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule

@@ sv/text_mode_console_engine.sv @@
// Top level of the text-mode console engine: sequencer, cursors and the two
// cell memories. Depends on tmc_pkg, tmc_if and tmc_ram.
//
//   channel   dir  beat contents
//   req_chan  in   op, arg_byte, page_arg, attribute, start_or_count, end_or_position
//   rsp_chan  out  read_char, read_attr, cursor_row, cursor_col, active_page, status
//
// One beat is processed at a time through a single-port address unit shared
// by both memories. Simple ops pass from DECODE straight to RESP; a repeated
// write writes one cell per cycle; a scroll or clear writes a blanked cell in
// SCR_CELL, and reads a copied cell in SCR_CELL and writes it in SCR_WR.
// After reset a clearing pass zeroes both memories before the
// first request is taken. A stalled response holds the engine before IDLE.
`timescale 1ns / 1ps
module text_mode_console_engine import tmc_pkg::*; (
   input logic       clock,
   input logic       reset,
   tmc_req_if.sink   req_chan,
   tmc_rsp_if.source rsp_chan
);
   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_SCR_CELL, S_SCR_WR, S_REP_WR, S_CELL_ADDR, S_RESP
   } state_type;

   state_type         state_ff;
   logic [MEM_W-1:0]  clr_ff;
   req_type           req_ff;
   logic [PAGE_W-1:0] shown_ff;
   logic [ROW_W-1:0]  cur_row_ff [PAGE_COUNT];
   logic [COL_W-1:0]  cur_col_ff [PAGE_COUNT];
   logic [PAGE_W-1:0] rpage_ff;
   logic              status_ff;
   logic [ROW_W-1:0]  y1_ff, y2_ff, y_ff;
   logic [COL_W-1:0]  x1_ff, x2_ff, x_ff;
   logic [7:0]        lines_ff;
   logic [15:0]       fill_ff;
   logic              up_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [PAGE_W-1:0] cur_sel;
   logic [ROW_W-1:0]  sel_row;
   logic [COL_W-1:0]  sel_col;
   logic [8:0]        scr_sum;
   logic              copy;
   logic [ROW_W-1:0]  src_row;
   logic              row_last;
   logic [7:0]        tt_col;
   logic [5:0]        tt_row;
   logic              tt_write;
   logic              tt_scroll;
   logic              on_active;
   logic [ROW_W-1:0]  ay;
   logic [COL_W-1:0]  ax;
   logic              cell_we;
   logic [15:0]       page_wdata, vis_wdata;
   logic [IDX_W-1:0]  idx;
   logic              page_we, vis_we;
   logic [MEM_W-1:0]  page_addr;
   logic [IDX_W-1:0]  vis_addr;
   logic [15:0]       page_rdata, vis_rdata;
   logic [ROW_W-1:0]  r_clamp;
   logic [COL_W-1:0]  c_clamp, x2_clamp;
   logic [ROW_W-1:0]  y2_clamp;
   logic [PAGE_W-1:0] bh_clamp, al_clamp, rc_page;

   assign on_active = (req_ff.page_arg == 8'(shown_ff));
   assign cur_sel   = (state_ff == S_CELL_ADDR || state_ff == S_RESP) ? rpage_ff : shown_ff;
   assign sel_row   = cur_row_ff[cur_sel];
   assign sel_col   = cur_col_ff[cur_sel];

   assign scr_sum  = 9'(y_ff) + 9'(lines_ff);
   assign copy     = up_ff ? (scr_sum <= 9'(y2_ff)) : (9'(y_ff) >= 9'(y1_ff) + 9'(lines_ff));
   assign src_row  = up_ff ? scr_sum[ROW_W-1:0] : y_ff - lines_ff[ROW_W-1:0];
   assign row_last = up_ff ? (y_ff == y2_ff) : (y_ff == y1_ff);

   assign r_clamp  = (req_ff.end_or_position[15:8] >= 8'(ROWS)) ?
                     ROW_W'(ROWS - 1) : req_ff.end_or_position[8 +: ROW_W];
   assign c_clamp  = (req_ff.end_or_position[7:0] >= 8'(COLUMNS)) ?
                     COL_W'(COLUMNS - 1) : req_ff.end_or_position[COL_W-1:0];
   assign y2_clamp = r_clamp;
   assign x2_clamp = c_clamp;
   assign bh_clamp = (req_ff.page_arg >= 8'(PAGE_COUNT)) ?
                     PAGE_W'(PAGE_COUNT - 1) : req_ff.page_arg[PAGE_W-1:0];
   assign al_clamp = (req_ff.arg_byte >= 8'(PAGE_COUNT)) ?
                     PAGE_W'(PAGE_COUNT - 1) : req_ff.arg_byte[PAGE_W-1:0];
   assign rc_page  = (req_ff.page_arg[3:0] >= 4'(PAGE_COUNT)) ?
                     PAGE_W'(0) : req_ff.page_arg[PAGE_W-1:0];

   always_comb begin
      tt_col    = 8'(sel_col);
      tt_row    = 6'(sel_row);
      tt_write  = 1'b0;
      tt_scroll = 1'b0;
      case (req_ff.arg_byte)
         CH_LF:  tt_row = tt_row + 6'd1;
         CH_CR:  tt_col = 8'd0;
         CH_BS:  if (tt_col != 8'd0) tt_col = tt_col - 8'd1;
         CH_BEL: ;
         default: begin
            tt_write = 1'b1;
            tt_col   = tt_col + 8'd1;
         end
      endcase
      if (tt_col >= 8'(COLUMNS)) begin
         tt_col = 8'd0;
         tt_row = tt_row + 6'd1;
      end
      if (tt_row >= 6'(ROWS)) begin
         tt_row    = 6'(ROWS - 1);
         tt_scroll = 1'b1;
      end
   end

   always_comb begin
      ay         = y_ff;
      ax         = x_ff;
      cell_we    = 1'b0;
      page_wdata = {req_ff.attribute, req_ff.arg_byte};
      vis_wdata  = {req_ff.attribute, req_ff.arg_byte};
      unique case (state_ff) inside
         S_SCR_CELL: begin
            ay         = copy ? src_row : y_ff;
            cell_we    = !copy;
            page_wdata = fill_ff;
            vis_wdata  = fill_ff;
         end
         S_SCR_WR: begin
            cell_we    = 1'b1;
            page_wdata = page_rdata;
            vis_wdata  = vis_rdata;
         end
         S_REP_WR: cell_we = 1'b1;
         S_DECODE: begin
            ay      = sel_row;
            ax      = sel_col;
            cell_we = (req_ff.op == OP_TELETYPE) && on_active && tt_write;
         end
         S_CELL_ADDR, S_RESP: begin
            ay = sel_row;
            ax = sel_col;
         end
         default: ;
      endcase
      idx = IDX_W'(ay) * IDX_W'(COLUMNS) + IDX_W'(ax);
      if (state_ff == S_CLEAR) begin
         page_addr  = clr_ff;
         vis_addr   = clr_ff[IDX_W-1:0];
         page_we    = 1'b1;
         vis_we     = (clr_ff < MEM_W'(PLANE_CELLS));
         page_wdata = '0;
         vis_wdata  = '0;
      end else begin
         page_addr = MEM_W'(shown_ff) * MEM_W'(PLANE_CELLS) + MEM_W'(idx);
         vis_addr  = idx;
         page_we   = cell_we;
         vis_we    = cell_we;
      end
   end

   tmc_ram #(.WIDTH(16), .DEPTH(ALL_CELLS)) u_page_ram (
      .clock (clock), .we (page_we), .addr (page_addr),
      .wdata (page_wdata), .rdata (page_rdata)
   );

   tmc_ram #(.WIDTH(16), .DEPTH(PLANE_CELLS)) u_vis_ram (
      .clock (clock), .we (vis_we), .addr (vis_addr),
      .wdata (vis_wdata), .rdata (vis_rdata)
   );

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         shown_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PAGE_COUNT; i++) begin
            cur_row_ff[i] <= '0;
            cur_col_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_chan.ready && state_ff != S_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff) inside
            S_CLEAR: begin
               clr_ff <= clr_ff + MEM_W'(1);
               if (clr_ff == MEM_W'(ALL_CELLS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_chan.valid) begin
                  req_ff    <= req_chan.payload;
                  rpage_ff  <= shown_ff;
                  status_ff <= 1'b0;
                  state_ff  <= S_DECODE;
               end
            end
            S_DECODE: begin
               state_ff <= S_RESP;
               y1_ff    <= '0;
               x1_ff    <= '0;
               y2_ff    <= ROW_W'(ROWS - 1);
               x2_ff    <= COL_W'(COLUMNS - 1);
               y_ff     <= '0;
               x_ff     <= '0;
               up_ff    <= 1'b1;
               fill_ff  <= BLANK_CELL;
               lines_ff <= 8'(ROWS);
               unique case (req_ff.op) inside
                  OP_SETMODE: begin
                     if (!req_ff.arg_byte[7]) begin
                        cur_row_ff[shown_ff] <= '0;
                        cur_col_ff[shown_ff] <= '0;
                        state_ff             <= S_SCR_CELL;
                     end
                  end
                  OP_SETCURSOR: begin
                     rpage_ff             <= bh_clamp;
                     cur_row_ff[bh_clamp] <= r_clamp;
                     cur_col_ff[bh_clamp] <= c_clamp;
                  end
                  OP_READCURSOR: rpage_ff <= bh_clamp;
                  OP_SELECTPAGE: begin
                     shown_ff <= al_clamp;
                     rpage_ff <= al_clamp;
                  end
                  OP_SCROLLUP, OP_SCROLLDOWN: begin
                     if (x2_clamp < req_ff.start_or_count[7:0] ||
                         y2_clamp < req_ff.start_or_count[15:8]) begin
                        status_ff <= 1'b1;
                     end else begin
                        y1_ff    <= req_ff.start_or_count[8 +: ROW_W];
                        x1_ff    <= req_ff.start_or_count[COL_W-1:0];
                        y2_ff    <= y2_clamp;
                        x2_ff    <= x2_clamp;
                        x_ff     <= req_ff.start_or_count[COL_W-1:0];
                        up_ff    <= (req_ff.op == OP_SCROLLUP);
                        y_ff     <= (req_ff.op == OP_SCROLLUP) ?
                                    req_ff.start_or_count[8 +: ROW_W] : y2_clamp;
                        fill_ff  <= {req_ff.page_arg, CH_SPC};
                        lines_ff <= (req_ff.arg_byte == 8'd0) ? 8'(ROWS) : req_ff.arg_byte;
                        state_ff <= S_SCR_CELL;
                     end
                  end
                  OP_READCELL: begin
                     rpage_ff <= rc_page;
                     state_ff <= S_CELL_ADDR;
                  end
                  OP_WRITEREP: begin
                     if (!on_active) begin
                        status_ff <= 1'b1;
                     end else if (req_ff.start_or_count != 16'd0) begin
                        y_ff     <= sel_row;
                        x_ff     <= sel_col;
                        cnt_ff   <= (req_ff.start_or_count > 16'(PLANE_CELLS)) ?
                                    CNT_W'(PLANE_CELLS) : req_ff.start_or_count[CNT_W-1:0];
                        state_ff <= S_REP_WR;
                     end
                  end
                  OP_TELETYPE: begin
                     if (!on_active) begin
                        status_ff <= 1'b1;
                     end else begin
                        cur_row_ff[shown_ff] <= tt_row[ROW_W-1:0];
                        cur_col_ff[shown_ff] <= tt_col[COL_W-1:0];
                        if (tt_scroll) begin
                           lines_ff <= 8'd1;
                           state_ff <= S_SCR_CELL;
                        end
                     end
                  end
                  OP_GETSTATE: ;
                  default: status_ff <= 1'b1;
               endcase
            end
            S_SCR_CELL, S_SCR_WR: begin
               if (state_ff == S_SCR_CELL && copy) begin
                  state_ff <= S_SCR_WR;
               end else begin
                  state_ff <= S_SCR_CELL;
                  if (x_ff == x2_ff) begin
                     x_ff <= x1_ff;
                     if (row_last) begin
                        state_ff <= S_RESP;
                     end else begin
                        y_ff <= up_ff ? y_ff + ROW_W'(1) : y_ff - ROW_W'(1);
                     end
                  end else begin
                     x_ff <= x_ff + COL_W'(1);
                  end
               end
            end
            S_REP_WR: begin
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_ff <= S_RESP;
               end
               if (x_ff == COL_W'(COLUMNS - 1)) begin
                  x_ff <= '0;
                  y_ff <= (y_ff == ROW_W'(ROWS - 1)) ? '0 : y_ff + ROW_W'(1);
               end else begin
                  x_ff <= x_ff + COL_W'(1);
               end
            end
            S_CELL_ADDR: state_ff <= S_RESP;
            S_RESP: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_ff.read_char    <= (req_ff.op == OP_READCELL) ? vis_rdata[7:0] : '0;
                  rsp_ff.read_attr    <= (req_ff.op == OP_READCELL) ? vis_rdata[15:8] : '0;
                  rsp_ff.cursor_row   <= sel_row;
                  rsp_ff.cursor_col   <= sel_col;
                  rsp_ff.active_page  <= shown_ff;
                  rsp_ff.status       <= status_ff;
                  state_ff            <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ sim/text_mode_console_engine_tb.sv @@
// Self-checking testbench for the text-mode console engine: a directed table
// followed by random requests, all checked against an in-bench console model.
// Depends on tmc_pkg, tmc_if and the engine RTL.
`timescale 1ns / 1ps
module text_mode_console_engine_tb;
   import tmc_pkg::*;

   localparam int STALL_LIMIT = 60000;
   localparam int REQ_BITS    = $bits(req_type);

   logic clock;
   logic reset;

   tmc_req_if req_chan ();
   tmc_rsp_if rsp_chan ();

   text_mode_console_engine u_top (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   logic [15:0] mdl_pages [ALL_CELLS];
   logic [15:0] mdl_screen [PLANE_CELLS];
   logic [COL_W-1:0] mdl_col [PAGE_COUNT];
   logic [ROW_W-1:0] mdl_row [PAGE_COUNT];
   logic [PAGE_W-1:0] mdl_shown;

   rsp_type expected_rsp [$];
   int errors;
   int table_errors;
   int send_idle_pct;
   int recv_idle_pct;
   bit hold_off;
   int quiet_cycles;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } dir_row;

   dir_row dir_rows [$];

   function automatic void put_both(int x, int y, logic [15:0] v);
      mdl_pages[mdl_shown * PLANE_CELLS + y * COLUMNS + x] = v;
      mdl_screen[y * COLUMNS + x] = v;
   endfunction

   function automatic void shift_window(int y1, int x1, int y2, int x2, int lines,
                                        logic [15:0] fill, bit up);
      int base;
      int lo;
      int hi;
      base = mdl_shown * PLANE_CELLS;
      if (up) begin
         for (int y = y1; y + lines <= y2; y++) begin
            for (int x = x1; x <= x2; x++) begin
               mdl_pages[base + y * COLUMNS + x] = mdl_pages[base + (y + lines) * COLUMNS + x];
               mdl_screen[y * COLUMNS + x] = mdl_screen[(y + lines) * COLUMNS + x];
            end
         end
         lo = (y2 - lines + 1 < y1) ? y1 : y2 - lines + 1;
         hi = y2;
      end else begin
         for (int y = y2; y >= y1 + lines; y--) begin
            for (int x = x1; x <= x2; x++) begin
               mdl_pages[base + y * COLUMNS + x] = mdl_pages[base + (y - lines) * COLUMNS + x];
               mdl_screen[y * COLUMNS + x] = mdl_screen[(y - lines) * COLUMNS + x];
            end
         end
         lo = y1;
         hi = (y1 + lines - 1 > y2) ? y2 : y1 + lines - 1;
      end
      for (int y = lo; y <= hi; y++) begin
         for (int x = x1; x <= x2; x++) begin
            put_both(x, y, fill);
         end
      end
   endfunction

   function automatic rsp_type console_step(req_type r);
      rsp_type o;
      int rp;
      int ap;
      int y1, x1, y2, x2, lines, px, py, n;
      logic [15:0] v;
      o = '0;
      ap = mdl_shown;
      rp = ap;
      case (r.op) inside
         OP_SETMODE: begin
            if (!r.arg_byte[7]) begin
               shift_window(0, 0, ROWS - 1, COLUMNS - 1, ROWS, BLANK_CELL, 1'b1);
               mdl_col[ap] = '0;
               mdl_row[ap] = '0;
            end
         end
         OP_SETCURSOR: begin
            rp = (r.page_arg >= PAGE_COUNT) ? PAGE_COUNT - 1 : r.page_arg;
            mdl_row[rp] = ROW_W'((r.end_or_position[15:8] >= ROWS) ? ROWS - 1
                                                             : r.end_or_position[15:8]);
            mdl_col[rp] = COL_W'((r.end_or_position[7:0] >= COLUMNS) ? COLUMNS - 1
                                                               : r.end_or_position[7:0]);
         end
         OP_READCURSOR: begin
            rp = (r.page_arg >= PAGE_COUNT) ? PAGE_COUNT - 1 : r.page_arg;
         end
         OP_SELECTPAGE: begin
            mdl_shown = PAGE_W'((r.arg_byte >= PAGE_COUNT) ? PAGE_COUNT - 1 : r.arg_byte);
            rp = mdl_shown;
         end
         OP_SCROLLUP, OP_SCROLLDOWN: begin
            y1 = r.start_or_count[15:8];
            x1 = r.start_or_count[7:0];
            y2 = r.end_or_position[15:8];
            x2 = r.end_or_position[7:0];
            lines = (r.arg_byte == 0) ? ROWS : r.arg_byte;
            if (y2 >= ROWS) y2 = ROWS - 1;
            if (x2 >= COLUMNS) x2 = COLUMNS - 1;
            if (x2 < x1 || y2 < y1) begin
               o.status = 1'b1;
            end else begin
               shift_window(y1, x1, y2, x2, lines, {r.page_arg, CH_SPC}, r.op == OP_SCROLLUP);
            end
         end
         OP_READCELL: begin
            rp = (r.page_arg[3:0] >= PAGE_COUNT) ? 0 : r.page_arg[3:0];
            v = mdl_screen[mdl_row[rp] * COLUMNS + mdl_col[rp]];
            o.read_char = v[7:0];
            o.read_attr = v[15:8];
         end
         OP_WRITEREP: begin
            if (r.page_arg != ap) begin
               o.status = 1'b1;
            end else begin
               px = mdl_col[ap];
               py = mdl_row[ap];
               n = (r.start_or_count > PLANE_CELLS) ? PLANE_CELLS : r.start_or_count;
               for (int i = 0; i < n; i++) begin
                  put_both(px, py, {r.attribute, r.arg_byte});
                  px++;
                  if (px >= COLUMNS) begin
                     px = 0;
                     py++;
                  end
                  if (py >= ROWS) py = 0;
               end
            end
         end
         OP_TELETYPE: begin
            if (r.page_arg != ap) begin
               o.status = 1'b1;
            end else begin
               px = mdl_col[ap];
               py = mdl_row[ap];
               if (r.arg_byte == CH_LF) py++;
               else if (r.arg_byte == CH_CR) px = 0;
               else if (r.arg_byte == CH_BS) begin
                  if (px > 0) px--;
               end else if (r.arg_byte != CH_BEL) begin
                  put_both(px, py, {r.attribute, r.arg_byte});
                  px++;
               end
               if (px >= COLUMNS) begin
                  px = px % COLUMNS;
                  py++;
               end
               if (py >= ROWS) begin
                  py = ROWS - 1;
                  shift_window(0, 0, ROWS - 1, COLUMNS - 1, 1, BLANK_CELL, 1'b1);
               end
               mdl_col[ap] = COL_W'(px);
               mdl_row[ap] = ROW_W'(py);
            end
         end
         OP_GETSTATE: ;
         default: o.status = 1'b1;
      endcase
      o.cursor_row = mdl_row[rp];
      o.cursor_col = mdl_col[rp];
      o.active_page = mdl_shown;
      return o;
   endfunction

   task automatic send_beat(req_type r);
      req_chan.valid <= 1'b1;
      req_chan.payload <= r;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_rsp.push_back(console_step(r));
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         req_chan.payload <= req_type'(REQ_BITS'({$urandom, $urandom}));
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
   endtask

   function automatic req_type make_req(logic [3:0] op, logic [7:0] al, logic [7:0] bh,
                                        logic [7:0] bl, logic [15:0] cx, logic [15:0] dx);
      req_type r;
      r.op = op;
      r.arg_byte = al;
      r.page_arg = bh;
      r.attribute = bl;
      r.start_or_count = cx;
      r.end_or_position = dx;
      return r;
   endfunction

   function automatic rsp_type make_rsp(logic [7:0] ch, logic [7:0] at, int row, int col,
                                        int pg, bit st);
      rsp_type o;
      o.read_char = ch;
      o.read_attr = at;
      o.cursor_row = ROW_W'(row);
      o.cursor_col = COL_W'(col);
      o.active_page = PAGE_W'(pg);
      o.status = st;
      return o;
   endfunction

   task automatic add_row(req_type r, bit typed, rsp_type o);
      dir_row d;
      d.req = r;
      d.typed = typed;
      d.rsp = o;
      dir_rows.push_back(d);
   endtask

   function automatic req_type random_req();
      req_type r;
      int pick;
      r = req_type'(REQ_BITS'({$urandom, $urandom}));
      pick = $urandom_range(99);
      if (pick < 40) begin
         r.op = OP_TELETYPE;
         r.page_arg = ($urandom_range(9) == 0) ? r.page_arg : 8'(mdl_shown);
         if ($urandom_range(3) == 0) r.arg_byte = ($urandom_range(1)) ? CH_LF : CH_CR;
      end else if (pick < 50) begin
         r.op = OP_WRITEREP;
         r.page_arg = ($urandom_range(5) == 0) ? r.page_arg : 8'(mdl_shown);
         if ($urandom_range(7) != 0) r.start_or_count = 16'($urandom_range(200));
      end else if (pick < 58) begin
         r.op = ($urandom_range(1)) ? OP_SCROLLUP : OP_SCROLLDOWN;
         r.arg_byte = 8'($urandom_range(6));
         if ($urandom_range(3) != 0) begin
            r.start_or_count = {8'($urandom_range(24)), 8'($urandom_range(79))};
            r.end_or_position = {8'($urandom_range(24)), 8'($urandom_range(79))};
         end
      end else if (pick < 70) begin
         r.op = OP_SETCURSOR;
         if ($urandom_range(2) != 0) r.page_arg = 8'($urandom_range(8));
         if ($urandom_range(2) != 0) r.end_or_position = {8'($urandom_range(26)),
                                                         8'($urandom_range(82))};
      end else if (pick < 78) begin
         r.op = OP_READCELL;
      end else if (pick < 83) begin
         r.op = OP_SELECTPAGE;
         if ($urandom_range(3) != 0) r.arg_byte = 8'($urandom_range(8));
      end else if (pick < 86) begin
         r.op = OP_SETMODE;
      end else if (pick < 95) begin
         r.op = ($urandom_range(1)) ? OP_READCURSOR : OP_GETSTATE;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %p", $time,
                     rsp_chan.payload);
            errors++;
         end else begin
            rsp_type e;
            e = expected_rsp.pop_front();
            if (rsp_chan.payload.read_char !== e.read_char
                || rsp_chan.payload.read_attr !== e.read_attr
                || rsp_chan.payload.cursor_row !== e.cursor_row
                || rsp_chan.payload.cursor_col !== e.cursor_col
                || rsp_chan.payload.active_page !== e.active_page
                || rsp_chan.payload.status !== e.status) begin
               $display("%0t: response mismatch, expected %p, actual %p", $time, e,
                        rsp_chan.payload);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      table_errors = 0;
      hold_off = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      for (int i = 0; i < ALL_CELLS; i++) mdl_pages[i] = '0;
      for (int i = 0; i < PLANE_CELLS; i++) mdl_screen[i] = '0;
      for (int i = 0; i < PAGE_COUNT; i++) begin
         mdl_col[i] = '0;
         mdl_row[i] = '0;
      end
      mdl_shown = '0;

      add_row(make_req(OP_READCELL, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000), 1,
              make_rsp(8'h00, 8'h00, 0, 0, 0, 0));
      add_row(make_req(OP_SETMODE, 8'h83, 8'h00, 8'h00, 16'h0000, 16'h0000), 1,
              make_rsp(8'h00, 8'h00, 0, 0, 0, 0));
      add_row(make_req(OP_SETCURSOR, 8'h00, 8'hFF, 8'h00, 16'h0000, 16'hFFFF), 1,
              make_rsp(8'h00, 8'h00, ROWS - 1, COLUMNS - 1, 0, 0));
      add_row(make_req(OP_READCURSOR, 8'h00, 8'h07, 8'h00, 16'h0000, 16'h0000), 1,
              make_rsp(8'h00, 8'h00, ROWS - 1, COLUMNS - 1, 0, 0));
      add_row(make_req(4'hF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF), 1,
              make_rsp(8'h00, 8'h00, 0, 0, 0, 1));
      add_row(make_req(4'hA, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000), 1,
              make_rsp(8'h00, 8'h00, 0, 0, 0, 1));
      add_row(make_req(OP_SETMODE, 8'h03, 8'h00, 8'h00, 16'h0000, 16'h0000), 1,
              make_rsp(8'h00, 8'h00, 0, 0, 0, 0));
      add_row(make_req(OP_READCELL, 8'h00, 8'h0F, 8'h00, 16'h0000, 16'h0000), 1,
              make_rsp(8'h20, 8'h07, 0, 0, 0, 0));
      add_row(make_req(OP_SCROLLUP, 8'h01, 8'h1F, 8'h00, 16'h0A0A, 16'h0505), 1,
              make_rsp(8'h00, 8'h00, 0, 0, 0, 1));
      add_row(make_req(OP_TELETYPE, 8'h41, 8'h03, 8'h1E, 16'h0000, 16'h0000), 1,
              make_rsp(8'h00, 8'h00, 0, 0, 0, 1));
      add_row(make_req(OP_WRITEREP, 8'h41, 8'h05, 8'h1E, 16'h0004, 16'h0000), 1,
              make_rsp(8'h00, 8'h00, 0, 0, 0, 1));
      add_row(make_req(OP_SETCURSOR, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h184E), 0, '0);
      add_row(make_req(OP_WRITEREP, 8'hFF, 8'h00, 8'hFF, 16'h0005, 16'h0000), 0, '0);
      add_row(make_req(OP_TELETYPE, 8'hFF, 8'h00, 8'h00, 16'h0000, 16'h0000), 0, '0);
      add_row(make_req(OP_TELETYPE, 8'h42, 8'h00, 8'h71, 16'h0000, 16'h0000), 0, '0);
      add_row(make_req(OP_TELETYPE, CH_BS, 8'h00, 8'h00, 16'h0000, 16'h0000), 0, '0);
      add_row(make_req(OP_TELETYPE, CH_BEL, 8'h00, 8'h00, 16'h0000, 16'h0000), 0, '0);
      add_row(make_req(OP_TELETYPE, CH_CR, 8'h00, 8'h00, 16'h0000, 16'h0000), 0, '0);
      add_row(make_req(OP_TELETYPE, CH_BS, 8'h00, 8'h00, 16'h0000, 16'h0000), 0, '0);
      add_row(make_req(OP_TELETYPE, CH_LF, 8'h00, 8'h00, 16'h0000, 16'h0000), 0, '0);
      add_row(make_req(OP_SCROLLDOWN, 8'h00, 8'hFF, 8'h00, 16'h0000, 16'hFFFF), 0, '0);
      add_row(make_req(OP_SCROLLUP, 8'hFF, 8'h00, 8'h00, 16'h0102, 16'h0A20), 0, '0);
      add_row(make_req(OP_SELECTPAGE, 8'hFF, 8'h00, 8'h00, 16'h0000, 16'h0000), 0, '0);
      add_row(make_req(OP_READCELL, 8'h00, 8'hF7, 8'h00, 16'h0000, 16'h0000), 0, '0);
      add_row(make_req(OP_GETSTATE, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000), 0, '0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_beat(dir_rows[i].req);
         if (dir_rows[i].typed && expected_rsp[$] !== dir_rows[i].rsp) begin
            $display("%0t: table row %0d disagrees, expected %p, actual %p", $time, i,
                     dir_rows[i].rsp, expected_rsp[$]);
            table_errors++;
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 57 : 0;
         recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 29 : 0;
         for (int n = 0; n < 37; n++) begin
            if (phase == 2 && n == 10) begin
               fork
                  begin
                     hold_off = 1'b1;
                     repeat (300) @(posedge clock);
                     hold_off = 1'b0;
                  end
                  for (int k = 0; k < 6; k++) send_beat(make_req(OP_GETSTATE, 8'($urandom),
                     8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom)));
               join
            end
            send_beat(random_req());
         end
      end
      req_chan.valid <= 1'b0;

      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0 && table_errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
